// ----- hw/rtl/bft_pkg.sv -----
// shared types and constants for the bidirectional flow table
package bft_pkg;

    // default number of flow entries
    localparam int unsigned BFT_CAPACITY = 256;

    // field widths of one packet word
    localparam int unsigned ADDR_KIND_W = 4;
    localparam int unsigned PORT_KIND_W = 3;
    localparam int unsigned KINDS_W     = ADDR_KIND_W + PORT_KIND_W;
    localparam int unsigned ADDR_W      = 32;
    localparam int unsigned PORT_W      = 16;
    localparam int unsigned FLOW_IDX_W  = 8;

    // packed stream widths
    localparam int unsigned IN_FIELDS_W = KINDS_W + 2 * ADDR_W + 2 * PORT_W;
    localparam int unsigned IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int unsigned OUT_TUSER_W = 2;

    // stored entry widths
    localparam int unsigned ENT_ADDR_W = 2 * ADDR_W;
    localparam int unsigned ENT_PORT_W = KINDS_W + 2 * PORT_W;

    // opcode values
    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    // result kinds loaded into the output register
    typedef logic [1:0] t_res_kind;
    localparam t_res_kind RES_MATCH = 2'd0;
    localparam t_res_kind RES_NEW   = 2'd1;
    localparam t_res_kind RES_FULL  = 2'd2;
    localparam t_res_kind RES_CLEAR = 2'd3;

    // commands from controller to datapath
    typedef struct packed {
        logic      load;       // capture probe word, restart the search
        logic      rd_issue;   // read the next stored entry
        logic      append;     // write probe at the fill index
        logic      clear_cnt;  // empty the table
        logic      res_load;   // load the output register
        t_res_kind res_kind;
    } t_bft_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic op_clear;  // captured word is a clear
        logic hit;       // entry under compare matches the probe
        logic rd_done;   // every stored entry has been read
        logic full;      // no free entry left
        logic out_free;  // output register can take a word this cycle
    } t_bft_sts;

endpackage

// ----- hw/rtl/bft_ctrl.sv -----
// control state machine for the flow table search
module bft_ctrl
    import bft_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_bft_sts i_sts,
    output t_bft_cmd o_cmd
);

    localparam logic ST_IDLE   = 1'b0;
    localparam logic ST_SEARCH = 1'b1;

    logic r_state;
    logic n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                priority if (i_sts.op_clear) begin
                    if (i_sts.out_free) begin
                        o_cmd.clear_cnt = 1'b1;
                        o_cmd.res_load  = 1'b1;
                        o_cmd.res_kind  = RES_CLEAR;
                        n_state         = ST_IDLE;
                    end
                end else if (i_sts.hit) begin
                    if (i_sts.out_free) begin
                        o_cmd.res_load = 1'b1;
                        o_cmd.res_kind = RES_MATCH;
                        n_state        = ST_IDLE;
                    end
                end else if (!i_sts.rd_done) begin
                    o_cmd.rd_issue = 1'b1;
                end else begin
                    // search ran out without a match
                    if (i_sts.out_free) begin
                        o_cmd.res_load = 1'b1;
                        if (i_sts.full) begin
                            o_cmd.res_kind = RES_FULL;
                        end else begin
                            o_cmd.append   = 1'b1;
                            o_cmd.res_kind = RES_NEW;
                        end
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- hw/rtl/bft_datapath.sv -----
// probe registers, entry memories, compare logic and output register
module bft_datapath
    import bft_pkg::*;
#(
    parameter int unsigned CAPACITY = BFT_CAPACITY
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_op,
    input  logic [ADDR_KIND_W-1:0] i_addr_kind,
    input  logic [PORT_KIND_W-1:0] i_port_kind,
    input  logic [ADDR_W-1:0]      i_src_addr,
    input  logic [ADDR_W-1:0]      i_dst_addr,
    input  logic [PORT_W-1:0]      i_src_port_num,
    input  logic [PORT_W-1:0]      i_dst_port_num,
    input  t_bft_cmd               i_cmd,
    output t_bft_sts               o_sts,
    input  logic                   i_out_ready,
    output logic                   o_out_valid,
    output logic [FLOW_IDX_W-1:0]  o_flow_index,
    output logic                   o_is_new,
    output logic                   o_table_full
);

    localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(CAPACITY);

    // probe word
    logic                r_op;
    logic [KINDS_W-1:0]  r_kinds;
    logic [ADDR_W-1:0]   r_sa;
    logic [ADDR_W-1:0]   r_da;
    logic [PORT_W-1:0]   r_sp;
    logic [PORT_W-1:0]   r_dp;

    // table state
    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      r_rd_idx;
    logic                  r_ent_vld;
    logic [IDX_W-1:0]      r_ent_idx;
    logic [ENT_ADDR_W-1:0] r_ent_addr;
    logic [ENT_PORT_W-1:0] r_ent_port;

    logic [ENT_ADDR_W-1:0] addr_mem [CAPACITY];
    logic [ENT_PORT_W-1:0] port_mem [CAPACITY];

    // output register
    logic                  r_out_vld;
    logic [FLOW_IDX_W-1:0] r_out_idx;
    logic                  r_out_new;
    logic                  r_out_full;

    logic                  match;
    logic [ADDR_W-1:0]     esa;
    logic [ADDR_W-1:0]     eda;
    logic [PORT_W-1:0]     esp;
    logic [PORT_W-1:0]     edp;
    logic [KINDS_W-1:0]    ekinds;
    logic [IDX_W-1:0]      res_idx;
    logic [IDX_W+FLOW_IDX_W-1:0] res_idx_ext;

    // capture probe word
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_op;
            r_kinds <= {i_addr_kind, i_port_kind};
            r_sa    <= i_src_addr;
            r_da    <= i_dst_addr;
            r_sp    <= i_src_port_num;
            r_dp    <= i_dst_port_num;
        end
    end

    // fill count and read pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_rd_idx  <= '0;
            r_ent_vld <= 1'b0;
        end else begin
            if (i_cmd.clear_cnt) begin
                r_count <= '0;
            end else if (i_cmd.append) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (i_cmd.load) begin
                r_rd_idx  <= '0;
                r_ent_vld <= 1'b0;
            end else if (i_cmd.rd_issue) begin
                r_rd_idx  <= r_rd_idx + CNT_W'(1);
                r_ent_vld <= 1'b1;
            end
        end
    end

    // entry memories, one write and one registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.append) begin
            addr_mem[r_count[IDX_W-1:0]] <= {r_sa, r_da};
            port_mem[r_count[IDX_W-1:0]] <= {r_kinds, r_sp, r_dp};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_issue) begin
            r_ent_addr <= addr_mem[r_rd_idx[IDX_W-1:0]];
            r_ent_port <= port_mem[r_rd_idx[IDX_W-1:0]];
            r_ent_idx  <= r_rd_idx[IDX_W-1:0];
        end
    end

    // bidirectional match; crossed check only when source addresses differ
    always_comb begin
        esa    = r_ent_addr[ENT_ADDR_W-1:ADDR_W];
        eda    = r_ent_addr[ADDR_W-1:0];
        ekinds = r_ent_port[ENT_PORT_W-1:2*PORT_W];
        esp    = r_ent_port[2*PORT_W-1:PORT_W];
        edp    = r_ent_port[PORT_W-1:0];
        if (ekinds != r_kinds) begin
            match = 1'b0;
        end else if (r_sa == esa) begin
            match = (r_da == eda) && (r_sp == esp) && (r_dp == edp);
        end else begin
            match = (r_sa == eda) && (r_da == esa) && (r_sp == edp) && (r_dp == esp);
        end
    end

    assign o_sts.op_clear = (r_op == OP_CLEAR);
    assign o_sts.hit      = r_ent_vld && match;
    assign o_sts.rd_done  = (r_rd_idx == r_count);
    assign o_sts.full     = (r_count == CNT_MAX);
    assign o_sts.out_free = !r_out_vld || i_out_ready;

    // index reported with the result, low bits only
    assign res_idx     = (i_cmd.res_kind == RES_NEW) ? r_count[IDX_W-1:0] : r_ent_idx;
    assign res_idx_ext = {{FLOW_IDX_W{1'b0}}, res_idx};

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.res_load) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            unique case (i_cmd.res_kind)
                RES_MATCH: begin
                    r_out_idx  <= res_idx_ext[FLOW_IDX_W-1:0];
                    r_out_new  <= 1'b0;
                    r_out_full <= 1'b0;
                end
                RES_NEW: begin
                    r_out_idx  <= res_idx_ext[FLOW_IDX_W-1:0];
                    r_out_new  <= 1'b1;
                    r_out_full <= 1'b0;
                end
                RES_FULL: begin
                    r_out_idx  <= '0;
                    r_out_new  <= 1'b0;
                    r_out_full <= 1'b1;
                end
                RES_CLEAR: begin
                    r_out_idx  <= '0;
                    r_out_new  <= 1'b0;
                    r_out_full <= 1'b0;
                end
                default: begin
                    r_out_idx  <= '0;
                    r_out_new  <= 1'b0;
                    r_out_full <= 1'b0;
                end
            endcase
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_flow_index = r_out_idx;
    assign o_is_new     = r_out_new;
    assign o_table_full = r_out_full;

    // fill count stays within the table
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_MAX)
        else $error("flow count beyond capacity");

    // no append into a full table
    a_no_append_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.append |-> (r_count != CNT_MAX))
        else $error("append while table full");

    // reads only reach written entries
    a_read_written: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd_issue |-> (r_rd_idx < r_count))
        else $error("read beyond fill count");

    // a result never overwrites one not yet taken
    a_res_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.res_load |-> (!r_out_vld || i_out_ready))
        else $error("result overrun");

    // after a clear result the table is empty
    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.res_load && (i_cmd.res_kind == RES_CLEAR)) |=> (r_count == '0))
        else $error("clear left entries");

endmodule

// ----- hw/rtl/bidirectional_flow_table.sv -----
// top level of the bidirectional five-tuple flow table
//
//   channel  dir  group        word
//   s_axis   in   tdata/tuser  packet tuple, tuser carries the opcode
//   m_axis   out  tdata/tuser  flow index, tuser carries is_new and table_full
//
// a lookup reads the stored entries one at a time, in index order, through the
// single read port of the entry memory, and compares each with the probe; it
// loads its result at the first match, or after the final compare without one.
// a clear loads its result without any search.
// reset empties the table at once; entry memories keep no reset.
// a new word is taken only after the previous one has been resolved into the
// output register; a result still waiting there holds the finished search.
module bidirectional_flow_table
    import bft_pkg::*;
#(
    parameter int unsigned CAPACITY = BFT_CAPACITY
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // addr_kind[3:0], port_kind[6:4], src_addr[38:7], dst_addr[70:39],
    // src_port_num[86:71], dst_port_num[102:87], zero pad[103]
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    // opcode[0]
    input  logic                   i_s_axis_tuser,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // flow_index[7:0]
    output logic [FLOW_IDX_W-1:0]  o_m_axis_tdata,
    // is_new[0], table_full[1]
    output logic [OUT_TUSER_W-1:0] o_m_axis_tuser
);

    localparam int unsigned SA_LO = KINDS_W;
    localparam int unsigned DA_LO = SA_LO + ADDR_W;
    localparam int unsigned SP_LO = DA_LO + ADDR_W;
    localparam int unsigned DP_LO = SP_LO + PORT_W;

    t_bft_cmd cmd;
    t_bft_sts sts;
    logic     is_new;
    logic     table_full;

    // sequencing
    bft_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // storage and compare
    bft_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_op           (i_s_axis_tuser),
        .i_addr_kind    (i_s_axis_tdata[ADDR_KIND_W-1:0]),
        .i_port_kind    (i_s_axis_tdata[KINDS_W-1:ADDR_KIND_W]),
        .i_src_addr     (i_s_axis_tdata[SA_LO +: ADDR_W]),
        .i_dst_addr     (i_s_axis_tdata[DA_LO +: ADDR_W]),
        .i_src_port_num (i_s_axis_tdata[SP_LO +: PORT_W]),
        .i_dst_port_num (i_s_axis_tdata[DP_LO +: PORT_W]),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_out_ready    (i_m_axis_tready),
        .o_out_valid    (o_m_axis_tvalid),
        .o_flow_index   (o_m_axis_tdata),
        .o_is_new       (is_new),
        .o_table_full   (table_full)
    );

    assign o_m_axis_tuser = {table_full, is_new};

endmodule

// ----- tb/tb_bidirectional_flow_table.sv -----
// testbench for the bidirectional flow table: directed and random flow lookups
module tb_bidirectional_flow_table
    import bft_pkg::*;
();

    localparam int unsigned CYCLE_LIMIT = 2_000_000;

    // one packet tuple as offered on the input stream
    typedef struct packed {
        logic [ADDR_KIND_W-1:0] addr_kind;
        logic [PORT_KIND_W-1:0] port_kind;
        logic [ADDR_W-1:0]      src_addr;
        logic [ADDR_W-1:0]      dst_addr;
        logic [PORT_W-1:0]      sport;
        logic [PORT_W-1:0]      dport;
    } t_flow_tuple;

    // answer of the table for one word
    typedef struct packed {
        logic [FLOW_IDX_W-1:0] flow_index;
        logic                  is_new;
        logic                  table_full;
    } t_flow_verdict;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_s_axis_tvalid;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata;
    logic                   i_s_axis_tuser;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready;
    logic [FLOW_IDX_W-1:0]  o_m_axis_tdata;
    logic [OUT_TUSER_W-1:0] o_m_axis_tuser;

    // predicted table contents
    t_flow_tuple   flow_store [BFT_CAPACITY];
    int            flows_used = 0;
    t_flow_verdict pending_verdicts [$];

    int          mismatches  = 0;
    int          burst_left  = 0;
    bit          gaps_off    = 1'b0;
    int          hold_req    = 0;
    int unsigned cycle_count = 0;

    bidirectional_flow_table dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // cycle counter and run limit
    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    // table behavior for one accepted word, updates the predicted contents
    function automatic t_flow_verdict resolve_flow(logic op, t_flow_tuple t);
        t_flow_verdict v;
        t_flow_tuple   e;
        bit            hit;
        v = '0;
        if (op == OP_CLEAR) begin
            flows_used = 0;
            return v;
        end
        for (int i = 0; i < flows_used; i++) begin
            e = flow_store[i];
            if (e.addr_kind != t.addr_kind || e.port_kind != t.port_kind)
                hit = 1'b0;
            // equal sources pin the check to the same direction, crossed is skipped
            else if (t.src_addr == e.src_addr)
                hit = t.dst_addr == e.dst_addr && t.sport == e.sport &&
                      t.dport == e.dport;
            else
                hit = t.src_addr == e.dst_addr && t.dst_addr == e.src_addr &&
                      t.sport == e.dport && t.dport == e.sport;
            if (hit) begin
                v.flow_index = FLOW_IDX_W'(i);
                return v;
            end
        end
        if (flows_used >= BFT_CAPACITY) begin
            v.table_full = 1'b1;
            return v;
        end
        flow_store[flows_used] = t;
        v.flow_index = FLOW_IDX_W'(flows_used);
        v.is_new     = 1'b1;
        flows_used++;
        return v;
    endfunction

    function automatic t_flow_tuple make_tuple(int unsigned ak, int unsigned pk,
                                               logic [ADDR_W-1:0] sa, logic [ADDR_W-1:0] da,
                                               logic [PORT_W-1:0] sp, logic [PORT_W-1:0] dp);
        t_flow_tuple t;
        t.addr_kind = ADDR_KIND_W'(ak);
        t.port_kind = PORT_KIND_W'(pk);
        t.src_addr  = sa;
        t.dst_addr  = da;
        t.sport     = sp;
        t.dport     = dp;
        return t;
    endfunction

    function automatic t_flow_tuple rand_tuple();
        return make_tuple($urandom_range(0, 15), $urandom_range(0, 7), $urandom, $urandom,
                          PORT_W'($urandom), PORT_W'($urandom));
    endfunction

    // few values, so equal addresses and partial matches come up often
    function automatic t_flow_tuple pool_tuple();
        logic [ADDR_W-1:0] a_pool [4];
        logic [PORT_W-1:0] p_pool [4];
        a_pool = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0A00_0001, 32'h0A00_0002};
        p_pool = '{16'd0, 16'd80, 16'd443, 16'hFFFF};
        return make_tuple($urandom_range(0, 1), $urandom_range(0, 1) * 6,
                          a_pool[$urandom_range(0, 3)], a_pool[$urandom_range(0, 3)],
                          p_pool[$urandom_range(0, 3)], p_pool[$urandom_range(0, 3)]);
    endfunction

    // same flow seen from the other end
    function automatic t_flow_tuple reverse_flow(t_flow_tuple t);
        t_flow_tuple r;
        r          = t;
        r.src_addr = t.dst_addr;
        r.dst_addr = t.src_addr;
        r.sport    = t.dport;
        r.dport    = t.sport;
        return r;
    endfunction

    // offer one word in bursts with random gaps, predict it once accepted
    task automatic send_word(input logic op, input t_flow_tuple t);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0 || gaps_off) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= op;
        // addr_kind, port_kind, src_addr, dst_addr, sport, dport from bit 0 up
        i_s_axis_tdata  <= IN_TDATA_W'({t.dport, t.sport, t.dst_addr, t.src_addr,
                                        t.port_kind, t.addr_kind});
        do @(posedge i_clk); while (o_s_axis_tready !== 1'b1);
        pending_verdicts.push_back(resolve_flow(op, t));
    endtask

    // sender idles until every expected result is back
    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_verdicts.size() != 0);
    endtask

    // receiver: phases of different stall density, plus a long hold on request
    initial begin
        int hold_cnt;
        int phase_left;
        int ready_pct;
        hold_cnt   = 0;
        phase_left = 0;
        ready_pct  = 100;
        i_m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req != 0) begin
                hold_cnt = hold_req;
                hold_req = 0;
            end
            if (phase_left == 0) begin
                phase_left = $urandom_range(20, 200);
                case ($urandom_range(0, 3))
                    0: ready_pct = 100;
                    1: ready_pct = 75;
                    2: ready_pct = 40;
                    default: ready_pct = 10;
                endcase
            end
            phase_left--;
            if (hold_cnt > 0) begin
                hold_cnt--;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= ($urandom_range(0, 99) < ready_pct);
            end
        end
    end

    // compare each result word with the oldest prediction
    always @(posedge i_clk) begin
        t_flow_verdict want;
        if (i_rst_n === 1'b1 && o_m_axis_tvalid === 1'b1 && i_m_axis_tready === 1'b1) begin
            if (pending_verdicts.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual index %0d tuser %b",
                         $time, o_m_axis_tdata, o_m_axis_tuser);
                mismatches++;
            end else begin
                want = pending_verdicts.pop_front();
                if (o_m_axis_tdata !== want.flow_index) begin
                    $display("%0t: flow_index expected %0d actual %0d",
                             $time, want.flow_index, o_m_axis_tdata);
                    mismatches++;
                end
                if (o_m_axis_tuser[0] !== want.is_new) begin
                    $display("%0t: is_new expected %b actual %b",
                             $time, want.is_new, o_m_axis_tuser[0]);
                    mismatches++;
                end
                if (o_m_axis_tuser[1] !== want.table_full) begin
                    $display("%0t: table_full expected %b actual %b",
                             $time, want.table_full, o_m_axis_tuser[1]);
                    mismatches++;
                end
            end
        end
    end

    // extremes, both directions, near misses, equal-address quirk, clear
    task automatic test_directed_cases();
        t_flow_tuple t2;
        t_flow_tuple t3;
        t_flow_tuple v;
        t2 = make_tuple(4, 6, 32'h0A00_0001, 32'hC0A8_0001, 16'd1234, 16'd80);
        t3 = make_tuple(1, 2, 32'h55AA_55AA, 32'h55AA_55AA, 16'd5000, 16'd6000);
        send_word(OP_CLEAR, make_tuple(15, 7, '1, '1, '1, '1));
        send_word(OP_LOOKUP, make_tuple(0, 0, '0, '0, '0, '0));
        send_word(OP_LOOKUP, make_tuple(15, 7, '1, '1, '1, '1));
        send_word(OP_LOOKUP, make_tuple(0, 0, '0, '0, '0, '0));
        send_word(OP_LOOKUP, t2);
        send_word(OP_LOOKUP, reverse_flow(t2));
        v = t2;
        v.addr_kind = 4'd5;
        send_word(OP_LOOKUP, v);
        v = t2;
        v.port_kind = 3'd1;
        send_word(OP_LOOKUP, v);
        // same addresses, ports crossed: no match in the same direction
        v = t2;
        v.sport = t2.dport;
        v.dport = t2.sport;
        send_word(OP_LOOKUP, v);
        // equal source and destination: a crossed port match is never tried
        send_word(OP_LOOKUP, t3);
        send_word(OP_LOOKUP, reverse_flow(t3));
        send_word(OP_LOOKUP, t3);
        // addresses crossed but ports not
        v = t2;
        v.src_addr = t2.dst_addr;
        v.dst_addr = t2.src_addr;
        send_word(OP_LOOKUP, v);
        v = t2;
        v.dst_addr = 32'hC0A8_0002;
        send_word(OP_LOOKUP, v);
        send_word(OP_LOOKUP, reverse_flow(make_tuple(15, 7, '1, '1, '1, '1)));
        send_word(OP_CLEAR, t2);
        send_word(OP_LOOKUP, t2);
        send_word(OP_CLEAR, '0);
    endtask

    // fill every entry, then new flows are refused while stored ones still match
    task automatic test_fill_and_full();
        t_flow_tuple t;
        send_word(OP_CLEAR, rand_tuple());
        repeat (BFT_CAPACITY) send_word(OP_LOOKUP, rand_tuple());
        repeat (4) send_word(OP_LOOKUP, rand_tuple());
        send_word(OP_LOOKUP, flow_store[flows_used - 1]);
        send_word(OP_LOOKUP, reverse_flow(flow_store[flows_used - 1]));
        send_word(OP_LOOKUP, reverse_flow(flow_store[0]));
        repeat (6) begin
            t = flow_store[$urandom_range(0, flows_used - 1)];
            send_word(OP_LOOKUP, $urandom_range(0, 1) ? reverse_flow(t) : t);
            send_word(OP_LOOKUP, pool_tuple());
        end
        send_word(OP_CLEAR, rand_tuple());
        send_word(OP_LOOKUP, rand_tuple());
    endtask

    // long receiver hold while words keep coming, so the input stalls
    task automatic test_output_hold();
        wait_drained();
        hold_req = 400;
        gaps_off = 1'b1;
        repeat (6) begin
            send_word(OP_LOOKUP, rand_tuple());
            send_word(OP_LOOKUP, pool_tuple());
        end
        gaps_off = 1'b0;
    endtask

    // short bursts, each followed by a full drain
    task automatic test_drain_pause();
        repeat (4) begin
            repeat ($urandom_range(3, 8)) send_word(OP_LOOKUP, pool_tuple());
            wait_drained();
        end
    endtask

    // mostly revisits of stored flows, some near misses, pool and random noise
    task automatic test_random_traffic(input int n_items);
        t_flow_tuple t;
        logic        op;
        int unsigned roll;
        repeat (n_items) begin
            op   = OP_LOOKUP;
            roll = $urandom_range(0, 99);
            if (roll < 3) begin
                op = OP_CLEAR;
                t  = rand_tuple();
            end else if (roll < 63 && flows_used > 0) begin
                t = flow_store[$urandom_range(0, flows_used - 1)];
                if ($urandom_range(0, 1)) t = reverse_flow(t);
                // near miss: flip one bit in one field
                if ($urandom_range(0, 4) == 0) begin
                    case ($urandom_range(0, 5))
                        0: t.addr_kind[$urandom_range(0, ADDR_KIND_W - 1)] ^= 1'b1;
                        1: t.port_kind[$urandom_range(0, PORT_KIND_W - 1)] ^= 1'b1;
                        2: t.src_addr[$urandom_range(0, ADDR_W - 1)] ^= 1'b1;
                        3: t.dst_addr[$urandom_range(0, ADDR_W - 1)] ^= 1'b1;
                        4: t.sport[$urandom_range(0, PORT_W - 1)] ^= 1'b1;
                        default: t.dport[$urandom_range(0, PORT_W - 1)] ^= 1'b1;
                    endcase
                end
            end else if (roll < 80) begin
                t = pool_tuple();
            end else begin
                t = rand_tuple();
            end
            send_word(op, t);
            if ($urandom_range(0, 79) == 0) wait_drained();
        end
    endtask

    // reset, tests in turn, final verdict
    initial begin
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_s_axis_tuser  <= OP_LOOKUP;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_cases();
        test_fill_and_full();
        test_output_hold();
        test_drain_pause();
        test_random_traffic(680);
        wait_drained();
        repeat (BFT_CAPACITY + 8) @(posedge i_clk);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/bft_pkg.sv
hw/rtl/bft_ctrl.sv
hw/rtl/bft_datapath.sv
hw/rtl/bidirectional_flow_table.sv
tb/tb_bidirectional_flow_table.sv
